### hdl/scd_pkg.sv
`default_nettype none

package scd_pkg;

  // Command codes on the request channel
  localparam logic [1:0] CMD_SET    = 2'd0;
  localparam logic [1:0] CMD_SOLVE  = 2'd1;
  localparam logic [1:0] CMD_WORKER = 2'd2;

  // Mixer constants
  localparam logic [63:0] MIX_GOLDEN = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MIX_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94d0_49bb_1331_11eb;
  localparam int unsigned MIX_SHIFT_A = 30;
  localparam int unsigned MIX_SHIFT_B = 27;
  localparam int unsigned MIX_SHIFT_C = 31;

  // Domain tags
  localparam logic [63:0] SOLVE_TAG  = 64'h0005_01e0_0000_0000;
  localparam logic [63:0] WORKER_TAG = 64'h0000_0107_ce00_0000;

  // Mixer sequencer
  typedef enum logic [2:0] {
    MIX_IDLE,
    MIX_ADD,
    MIX_M0,
    MIX_M1,
    MIX_M2,
    MIX_XS,
    MIX_DONE
  } mix_state_t;

  // Top level sequencer
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_HOLD
  } seq_state_t;

endpackage

`default_nettype wire

### hdl/scd_mix_core.sv
`default_nettype none

module scd_mix_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] x_init,
  input  wire logic [63:0] key,
  output logic             done,
  output logic [63:0]      h
);
  import scd_pkg::*;

  mix_state_t  state;
  mix_state_t  state_next;
  logic [63:0] x;
  logic [63:0] x_next;
  logic [63:0] acc;
  logic [63:0] acc_next;
  logic        pass;
  logic        pass_next;
  logic        mul_sel;
  logic        mul_sel_next;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_c;
  logic [63:0] prod;
  logic [63:0] sum_g;
  logic [63:0] fin;

  // One shared 32x32 multiplier; a 64-bit product mod 2^64 is built from three partial products
  assign mul_c = mul_sel ? MIX_MUL_B : MIX_MUL_A;
  assign mul_a = (state == MIX_M2) ? x[63:32] : x[31:0];
  assign mul_b = (state == MIX_M1) ? mul_c[63:32] : mul_c[31:0];
  assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

  assign sum_g = x + MIX_GOLDEN;
  assign fin   = acc ^ (acc >> MIX_SHIFT_C);

  always_comb begin
    state_next = state;
    unique case (state)
      MIX_IDLE: if (start) state_next = MIX_ADD;
      MIX_ADD:  state_next = MIX_M0;
      MIX_M0:   state_next = MIX_M1;
      MIX_M1:   state_next = MIX_M2;
      MIX_M2:   state_next = MIX_XS;
      MIX_XS: begin
        if (!mul_sel) state_next = MIX_M0;
        else if (!pass) state_next = MIX_ADD;
        else state_next = MIX_DONE;
      end
      MIX_DONE: state_next = MIX_IDLE;
      default:  state_next = MIX_IDLE;
    endcase
  end

  always_comb begin
    x_next       = x;
    acc_next     = acc;
    pass_next    = pass;
    mul_sel_next = mul_sel;
    unique case (state)
      MIX_IDLE: begin
        if (start) begin
          x_next    = x_init;
          pass_next = 1'b0;
        end
      end
      MIX_ADD: begin
        x_next       = sum_g ^ (sum_g >> MIX_SHIFT_A);
        mul_sel_next = 1'b0;
      end
      MIX_M0: acc_next = prod;
      MIX_M1: acc_next = {acc[63:32] + prod[31:0], acc[31:0]};
      MIX_M2: acc_next = {acc[63:32] + prod[31:0], acc[31:0]};
      MIX_XS: begin
        if (!mul_sel) begin
          x_next       = acc ^ (acc >> MIX_SHIFT_B);
          mul_sel_next = 1'b1;
        end else if (!pass) begin
          // fold inner mix into the outer operand
          x_next    = key ^ fin;
          pass_next = 1'b1;
        end else begin
          x_next = fin;
        end
      end
      MIX_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MIX_IDLE;
    end else begin
      state <= state_next;
    end
    x       <= x_next;
    acc     <= acc_next;
    pass    <= pass_next;
    mul_sel <= mul_sel_next;
  end

  assign done = (state == MIX_DONE);
  assign h    = x;

endmodule

`default_nettype wire

### hdl/seed_chain_derivation.sv
`default_nettype none

// Seed chain derivation: holds a 64-bit master seed and a solve ordinal and
// answers one request with one result (command 3 is dropped with no result).
// A set request loads the master (a zero seed takes the entropy word, or 1)
// and clears the ordinal; its result leaves in the cycle after acceptance.
// A solve or worker derive request runs two splitmix64 passes on one shared
// 32x32 multiplier, three partial products per 64-bit product and four
// products in all; the result is registered once the mixer is done and free.
// The block takes a new request once the sequencer is idle and the output
// register is free or being taken; an unset master is filled from entropy
// before a derive and used_entropy flags that.
module seed_chain_derivation (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [63:0] seed_value,
  input  wire logic [63:0] rank_index,
  input  wire logic [31:0] entropy_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      seed_out,
  output logic             used_entropy
);
  import scd_pkg::*;

  seq_state_t  state;
  seq_state_t  state_next;
  logic [63:0] master;
  logic [63:0] ordinal;
  logic        solve_q;
  logic        used_q;

  logic        accept;
  logic        out_free;
  logic        start;
  logic        done;
  logic [63:0] h;
  logic [63:0] x_init;
  logic [63:0] key;
  logic [63:0] ent_seed;
  logic [63:0] derived;
  logic        wr_set;
  logic        wr_derive;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != SEQ_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign ent_seed = (entropy_word == 32'd0) ? 64'd1 : {32'd0, entropy_word};

  assign start  = accept && (cmd == CMD_SOLVE || cmd == CMD_WORKER);
  assign x_init = (cmd == CMD_SOLVE) ? ordinal : rank_index;
  // master and solve_q hold steady for the whole run
  assign key    = master ^ (solve_q ? SOLVE_TAG : WORKER_TAG);

  scd_mix_core u_mix (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .x_init (x_init),
    .key    (key),
    .done   (done),
    .h      (h)
  );

  // Solve seeds keep a nonzero 32-bit half; worker seeds a nonzero word
  always_comb begin
    if (solve_q) begin
      if (h[31:0] != 32'd0) derived = {32'd0, h[31:0]};
      else if (h[63:32] != 32'd0) derived = {32'd0, h[63:32]};
      else derived = 64'd1;
    end else begin
      derived = (h != 64'd0) ? h : 64'd1;
    end
  end

  assign wr_set    = accept && (cmd == CMD_SET);
  assign wr_derive = ((state == SEQ_RUN && done) || state == SEQ_HOLD) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: if (start) state_next = SEQ_RUN;
      SEQ_RUN: begin
        if (done) state_next = out_free ? SEQ_IDLE : SEQ_HOLD;
      end
      SEQ_HOLD: if (out_free) state_next = SEQ_IDLE;
      default:  state_next = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SEQ_IDLE;
      master    <= 64'd0;
      ordinal   <= 64'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        unique case (cmd)
          CMD_SET: begin
            master  <= (seed_value == 64'd0) ? ent_seed : seed_value;
            ordinal <= 64'd0;
          end
          CMD_SOLVE, CMD_WORKER: begin
            // fill an unset master from entropy; a solve advances the ordinal
            if (master == 64'd0) master <= ent_seed;
            if (cmd == CMD_SOLVE) ordinal <= ordinal + 64'd1;
          end
          default: ;
        endcase
      end
      if (wr_set || wr_derive) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
    if (start) begin
      solve_q <= (cmd == CMD_SOLVE);
      used_q  <= (master == 64'd0);
    end
    if (wr_set) begin
      seed_out     <= (seed_value == 64'd0) ? ent_seed : seed_value;
      used_entropy <= (seed_value == 64'd0);
    end else if (wr_derive) begin
      seed_out     <= derived;
      used_entropy <= used_q;
    end
  end

endmodule

`default_nettype wire
